[src/hfe_pkg.sv]
// Shared constants, types and escape test of the HDLC frame encoder.
`default_nettype none
package hfe_pkg;

    localparam logic [7:0]  FLAG_BYTE  = 8'h7E;
    localparam logic [7:0]  ESC_BYTE   = 8'h7D;
    // 0x7D -> 0x5D and 0x7E -> 0x5E: flip bit 5
    localparam logic [7:0]  ESC_XOR    = 8'h20;
    localparam logic [15:0] CRC_POLY   = 16'h1021;
    localparam int          BYTE_BITS  = 8;

    typedef logic [7:0]  byte_t;
    typedef logic [15:0] crc_t;

    function automatic logic needs_escape(input byte_t b);
        needs_escape = (b == ESC_BYTE) || (b == FLAG_BYTE);
    endfunction

endpackage
`default_nettype wire

[src/hfe_in_if.sv]
// Input channel: payload byte with end-of-frame mark.
`default_nettype none
interface hfe_in_if;
    import hfe_pkg::*;

    logic  valid;
    logic  ready;
    byte_t data_byte;
    logic  last_in;

    modport source (output valid, output data_byte, output last_in, input ready);
    modport sink   (input valid, input data_byte, input last_in, output ready);
endinterface
`default_nettype wire

[src/hfe_out_if.sv]
// Output channel: framed line byte with closing-flag mark.
`default_nettype none
interface hfe_out_if;
    import hfe_pkg::*;

    logic  valid;
    logic  ready;
    byte_t out_byte;
    logic  last_out;

    modport source (output valid, output out_byte, output last_out, input ready);
    modport sink   (input valid, input out_byte, input last_out, output ready);
endinterface
`default_nettype wire

[src/hfe_crc16.sv]
// CRC-16 (poly 0x1021, MSB first) update over one byte.
`default_nettype none
module hfe_crc16
    import hfe_pkg::*;
(
    input  wire crc_t  crc_in,
    input  wire byte_t data,
    output crc_t       crc_out
);

    always_comb
    begin
        crc_t c;
        c = crc_in ^ {data, 8'h00};
        for (int k = 0; k < BYTE_BITS; k++)
        begin
            if (c[15])
            begin
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            end
            else
            begin
                c = {c[14:0], 1'b0};
            end
        end
        crc_out = c;
    end

endmodule
`default_nettype wire

[src/hdlc_frame_encoder_crc16.sv]
// Top level: HDLC byte framer with escaping and CRC-16 trailer.
//
//  channel | dir | payload               | note
//  din     | in  | data_byte, last_in    | one payload byte per transfer
//  dout    | out | out_byte, last_out    | one line byte per transfer
//
// An accepted byte sits in an item register and goes out one line byte per
// cycle, unless dout stalls, through a registered output stage: one line
// byte for a plain byte, two for an escaped one, plus an opening flag on
// a frame's first byte and 3 to 5 trailer bytes on its last. The next byte
// is taken in the cycle the item's final line byte moves to the output
// register. A dout stall holds both registers. Reset closes open frames.
`default_nettype none
module hdlc_frame_encoder_crc16
    import hfe_pkg::*;
(
    input  wire       clk,
    input  wire       rst_n,
    hfe_in_if.sink    din,
    hfe_out_if.source dout
);

    typedef enum logic [2:0] {
        ST_FLAG,
        ST_DATA,
        ST_DATA_ESC,
        ST_CRCH,
        ST_CRCH_ESC,
        ST_CRCL,
        ST_CRCL_ESC,
        ST_CLOSE
    } step_t;

    // frame state
    crc_t  acc_reg;
    logic  open_reg;

    // item register
    logic  item_valid_reg;
    step_t step_reg;
    byte_t byte_reg;
    logic  last_reg;
    crc_t  crc_reg;

    // output register
    logic  out_valid_reg;
    byte_t out_byte_reg;
    logic  out_last_reg;

    crc_t  crc_seed;
    crc_t  crc_new;
    logic  emit;
    logic  accept;
    logic  done;
    step_t step_next;
    byte_t emit_byte;
    logic  emit_last;

    assign crc_seed = open_reg ? acc_reg : '0;

    hfe_crc16 u_crc (
        .crc_in  (crc_seed),
        .data    (din.data_byte),
        .crc_out (crc_new)
    );

    assign emit   = item_valid_reg && (!out_valid_reg || dout.ready);
    assign accept = din.valid && din.ready;
    assign din.ready = !item_valid_reg || (emit && done);

    always_comb
    begin
        step_next = step_reg;
        done      = 1'b0;
        emit_byte = FLAG_BYTE;
        emit_last = 1'b0;
        unique case (step_reg)
            ST_FLAG:
            begin
                emit_byte = FLAG_BYTE;
                step_next = ST_DATA;
            end
            ST_DATA:
            begin
                if (needs_escape(byte_reg))
                begin
                    emit_byte = ESC_BYTE;
                    step_next = ST_DATA_ESC;
                end
                else
                begin
                    emit_byte = byte_reg;
                    step_next = ST_CRCH;
                    done      = !last_reg;
                end
            end
            ST_DATA_ESC:
            begin
                emit_byte = byte_reg ^ ESC_XOR;
                step_next = ST_CRCH;
                done      = !last_reg;
            end
            ST_CRCH:
            begin
                if (needs_escape(crc_reg[15:8]))
                begin
                    emit_byte = ESC_BYTE;
                    step_next = ST_CRCH_ESC;
                end
                else
                begin
                    emit_byte = crc_reg[15:8];
                    step_next = ST_CRCL;
                end
            end
            ST_CRCH_ESC:
            begin
                emit_byte = crc_reg[15:8] ^ ESC_XOR;
                step_next = ST_CRCL;
            end
            ST_CRCL:
            begin
                if (needs_escape(crc_reg[7:0]))
                begin
                    emit_byte = ESC_BYTE;
                    step_next = ST_CRCL_ESC;
                end
                else
                begin
                    emit_byte = crc_reg[7:0];
                    step_next = ST_CLOSE;
                end
            end
            ST_CRCL_ESC:
            begin
                emit_byte = crc_reg[7:0] ^ ESC_XOR;
                step_next = ST_CLOSE;
            end
            ST_CLOSE:
            begin
                emit_byte = FLAG_BYTE;
                emit_last = 1'b1;
                done      = 1'b1;
            end
            default:
            begin
                done = 1'b1;
            end
        endcase
    end

    // state, item register and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg        <= '0;
            open_reg       <= 1'b0;
            item_valid_reg <= 1'b0;
            step_reg       <= ST_FLAG;
            byte_reg       <= '0;
            last_reg       <= 1'b0;
            crc_reg        <= '0;
            out_valid_reg  <= 1'b0;
            out_byte_reg   <= '0;
            out_last_reg   <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                item_valid_reg <= 1'b1;
                step_reg       <= open_reg ? ST_DATA : ST_FLAG;
                acc_reg        <= din.last_in ? '0 : crc_new;
                open_reg       <= !din.last_in;
                byte_reg       <= din.data_byte;
                last_reg       <= din.last_in;
                crc_reg        <= crc_new;
            end
            else if (emit)
            begin
                if (done)
                begin
                    item_valid_reg <= 1'b0;
                end
                step_reg <= step_next;
            end

            if (emit)
            begin
                out_valid_reg <= 1'b1;
                out_byte_reg  <= emit_byte;
                out_last_reg  <= emit_last;
            end
            else if (dout.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign dout.valid    = out_valid_reg;
    assign dout.out_byte = out_byte_reg;
    assign dout.last_out = out_last_reg;

endmodule
`default_nettype wire

[sim/tb.sv]
// Testbench for the HDLC frame encoder: directed table, random frames, line byte checks.
`timescale 1ns / 100ps
module tb
    import hfe_pkg::*;
();

    typedef struct packed {
        logic  last;
        byte_t value;
    } line_t;

    // One directed transfer; n_typed > 0 gives the line bytes by hand, right-aligned in typed.
    typedef struct packed {
        byte_t       data;
        logic        last;
        logic [3:0]  n_typed;
        logic [39:0] typed;
    } row_t;

    localparam int N_ROWS = 21;
    localparam row_t DIR_TAB [N_ROWS] = '{
        {8'h00, 1'b1, 4'd5, 40'h7E0000007E},
        {8'hFF, 1'b1, 4'd0, 40'h0},
        {8'h00, 1'b0, 4'd2, 40'h7E00},
        {8'h00, 1'b1, 4'd4, 40'h0000007E},
        {8'h7D, 1'b0, 4'd3, 40'h7E7D5D},
        {8'h7E, 1'b0, 4'd2, 40'h7D5E},
        {8'h7E, 1'b1, 4'd0, 40'h0},
        {8'h7E, 1'b1, 4'd0, 40'h0},
        {8'h7D, 1'b1, 4'd0, 40'h0},
        {8'hFF, 1'b0, 4'd2, 40'h7EFF},
        {8'hFF, 1'b0, 4'd1, 40'hFF},
        {8'h01, 1'b0, 4'd1, 40'h01},
        {8'h80, 1'b0, 4'd1, 40'h80},
        {8'h7C, 1'b0, 4'd1, 40'h7C},
        {8'h7F, 1'b0, 4'd1, 40'h7F},
        {8'h5D, 1'b0, 4'd1, 40'h5D},
        {8'h5E, 1'b1, 4'd0, 40'h0},
        {8'hAA, 1'b1, 4'd0, 40'h0},
        {8'h55, 1'b0, 4'd2, 40'h7E55},
        {8'h7D, 1'b0, 4'd2, 40'h7D5D},
        {8'h7D, 1'b1, 4'd0, 40'h0}
    };

    logic clk;
    logic rst_n;

    hfe_in_if  din_if ();
    hfe_out_if dout_if ();

    hdlc_frame_encoder_crc16 dut (
        .clk   (clk),
        .rst_n (rst_n),
        .din   (din_if),
        .dout  (dout_if)
    );

    line_t line_q [$];
    line_t enc_lines [$];
    crc_t  enc_crc = '0;
    logic  enc_open = 1'b0;
    int    err_count = 0;
    int    sent_total = 0;
    bit    src_idle_on = 1'b1;
    bit    sink_idle_on = 1'b1;
    bit    long_hold_req = 1'b0;

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        #400000;
        $display("Verification failed");
        $finish;
    end

    function automatic crc_t crc_byte(input crc_t c, input byte_t b);
        crc_t r;
        int   k;
        r = c ^ {b, 8'h00};
        for (k = 0; k < 8; k++)
            r = r[15] ? ((r << 1) ^ CRC_POLY) : (r << 1);
        return r;
    endfunction

    // Undo eight shift steps; bit 0 tells whether the top bit was set before the shift.
    function automatic crc_t crc_unshift8(input crc_t c);
        crc_t r;
        int   k;
        r = c;
        for (k = 0; k < 8; k++)
            r = r[0] ? (((r ^ CRC_POLY) >> 1) | 16'h8000) : (r >> 1);
        return r;
    endfunction

    function automatic byte_t pick_byte();
        case ($urandom_range(0, 9))
            0: return ESC_BYTE;
            1: return FLAG_BYTE;
            2: return 8'h00;
            3: return 8'hFF;
            default: return byte_t'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic put_line(input byte_t v, input logic l);
        enc_lines.push_back({l, v});
    endtask

    task automatic put_escaped(input byte_t v);
        if (v == ESC_BYTE || v == FLAG_BYTE)
        begin
            put_line(ESC_BYTE, 1'b0);
            put_line(v ^ ESC_XOR, 1'b0);
        end
        else
            put_line(v, 1'b0);
    endtask

    task automatic frame_encode(input byte_t b, input logic l);
        enc_lines.delete();
        if (!enc_open)
        begin
            put_line(FLAG_BYTE, 1'b0);
            enc_open = 1'b1;
            enc_crc  = '0;
        end
        put_escaped(b);
        enc_crc = crc_byte(enc_crc, b);
        if (l)
        begin
            put_escaped(enc_crc[15:8]);
            put_escaped(enc_crc[7:0]);
            put_line(FLAG_BYTE, 1'b1);
            enc_crc  = '0;
            enc_open = 1'b0;
        end
    endtask

    // Enter right after a rising edge; return at the edge of the transfer.
    task automatic send_item(input byte_t b, input logic l, input bit keep);
        int gap;
        int i;
        gap = src_idle_on ? $urandom_range(0, 7) : 0;
        if (gap > 0)
        begin
            din_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        din_if.valid     <= 1'b1;
        din_if.data_byte <= b;
        din_if.last_in   <= l;
        do @(posedge clk); while (!din_if.ready);
        frame_encode(b, l);
        sent_total++;
        if (keep)
            for (i = 0; i < enc_lines.size(); i++)
                line_q.push_back(enc_lines[i]);
    endtask

    task automatic drain_out();
        din_if.valid <= 1'b0;
        @(posedge clk);
        while (line_q.size() != 0) @(posedge clk);
    endtask

    // With force_crc, pick the last two bytes so the CRC lands on a value that needs escaping.
    task automatic send_frame(input int len, input bit force_crc);
        crc_t  tgt;
        crc_t  y;
        crc_t  x;
        crc_t  start;
        byte_t a;
        byte_t b;
        int    i;
        int    j;
        for (i = 0; i < len; i++)
        begin
            if (force_crc && i == len - 2)
            begin
                case ($urandom_range(0, 7))
                    0: tgt = 16'h7D7D;
                    1: tgt = 16'h7E7E;
                    2: tgt = 16'h7D7E;
                    3: tgt = 16'h7E7D;
                    4: tgt = 16'h007D;
                    5: tgt = 16'h7D00;
                    6: tgt = 16'h007E;
                    default: tgt = 16'h7E00;
                endcase
                start = enc_open ? enc_crc : 16'h0000;
                y = crc_unshift8(tgt);
                a = 8'h00;
                b = 8'h00;
                for (j = 0; j < 256; j++)
                begin
                    x = crc_byte(start, j[7:0]);
                    if (x[7:0] == y[7:0])
                    begin
                        a = j[7:0];
                        b = y[15:8] ^ x[15:8];
                    end
                end
                send_item(a, 1'b0, 1'b1);
                send_item(b, 1'b1, 1'b1);
                return;
            end
            send_item(pick_byte(), i == len - 1, 1'b1);
        end
    endtask

    task automatic random_frames(input int upto);
        int len;
        while (sent_total < upto)
        begin
            len = ($urandom_range(0, 15) == 0) ? $urandom_range(10, 24) : $urandom_range(1, 6);
            send_frame(len, len >= 2 && $urandom_range(0, 3) == 0);
        end
    endtask

    initial
    begin
        row_t r;
        int   i;
        int   k;
        din_if.valid     <= 1'b0;
        din_if.data_byte <= 8'h00;
        din_if.last_in   <= 1'b0;
        rst_n            <= 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (i = 0; i < N_ROWS; i++)
        begin
            r = DIR_TAB[i];
            send_item(r.data, r.last, r.n_typed == 0);
            for (k = 0; k < r.n_typed; k++)
                line_q.push_back({r.last && (k == r.n_typed - 1),
                                  r.typed[(r.n_typed - 1 - k) * 8 +: 8]});
        end

        random_frames(170);
        drain_out();

        // Sender at full rate while the receiver holds off
        src_idle_on   = 1'b0;
        long_hold_req = 1'b1;
        random_frames(240);

        sink_idle_on = 1'b0;
        random_frames(320);

        // Loose last marks
        src_idle_on  = 1'b1;
        sink_idle_on = 1'b1;
        while (sent_total < 470)
            send_item(pick_byte(), $urandom_range(0, 3) == 0, 1'b1);

        drain_out();
        repeat (20) @(posedge clk);
        if (err_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    initial
    begin
        int hold;
        dout_if.ready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (long_hold_req)
            begin
                long_hold_req = 1'b0;
                hold = 100;
            end
            else
                hold = sink_idle_on ? $urandom_range(0, 7) : 0;
            if (hold > 0)
            begin
                dout_if.ready <= 1'b0;
                repeat (hold) @(posedge clk);
            end
            dout_if.ready <= 1'b1;
            do @(posedge clk); while (!dout_if.valid);
        end
    end

    always @(posedge clk)
    begin
        line_t got;
        line_t want;
        if (rst_n && dout_if.valid && dout_if.ready)
        begin
            got = {dout_if.last_out, dout_if.out_byte};
            if (line_q.size() == 0)
            begin
                $display("%0t: unexpected line byte %h last %b", $time, got.value, got.last);
                err_count++;
            end
            else
            begin
                want = line_q.pop_front();
                if (got.value !== want.value || got.last !== want.last)
                begin
                    $display("%0t: line byte mismatch: expected %h last %b, got %h last %b",
                             $time, want.value, want.last, got.value, got.last);
                    err_count++;
                end
            end
        end
    end

endmodule
